[design/irpe_pkg.sv]
// ----------------------------------------------------------------------------
// irpe_pkg
// Shared types, timing constants and the microprogram of the IR pulse encoder.
// ----------------------------------------------------------------------------
package irpe_pkg;

    // Field widths
    localparam int ProtoW = 2;
    localparam int CmdW   = 8;
    localparam int SaddrW = 5;
    localparam int DurW   = 13;
    localparam int AddrW  = 8;
    localparam int CntW   = 5;
    localparam int ShiftW = 32;
    localparam int CfgIdxW = 2;

    // Packed stream widths
    localparam int STdataW = 16;  // command, sirc_address, padding
    localparam int MTdataW = 32;  // mark_us, space_us, padding

    // Protocol codes
    localparam logic [ProtoW-1:0] PROTO_NEC_A = 2'd0;
    localparam logic [ProtoW-1:0] PROTO_NEC_B = 2'd1;
    localparam logic [ProtoW-1:0] PROTO_SIRC  = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_NEC_ADDRESS_A = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NEC_ADDRESS_B = 2'd1;

    localparam logic [AddrW-1:0] NEC_ADDR_A_RST = 8'h07;
    localparam logic [AddrW-1:0] NEC_ADDR_B_RST = 8'h04;

    // Durations in microseconds
    localparam logic [DurW-1:0] T_4500 = 13'd4500;
    localparam logic [DurW-1:0] T_2400 = 13'd2400;
    localparam logic [DurW-1:0] T_1690 = 13'd1690;
    localparam logic [DurW-1:0] T_1200 = 13'd1200;
    localparam logic [DurW-1:0] T_600  = 13'd600;
    localparam logic [DurW-1:0] T_560  = 13'd560;
    localparam logic [DurW-1:0] T_0    = 13'd0;

    localparam logic [CntW-1:0] NEC_BITS_M1  = 5'd31;
    localparam logic [CntW-1:0] SIRC_BITS_M1 = 5'd11;

    // Microcode addresses
    typedef enum logic [2:0] {
        UA_IDLE,
        UA_NEC_HDR,
        UA_NEC_BIT,
        UA_NEC_END,
        UA_SIRC_HDR,
        UA_SIRC_BIT
    } upc_t;

    typedef enum logic [1:0] {
        MK_4500,
        MK_560,
        MK_2400,
        MK_SIRC_BIT
    } mark_sel_t;

    typedef enum logic [1:0] {
        SP_4500,
        SP_600,
        SP_NEC_BIT,
        SP_ZERO
    } space_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_CNT_ZERO
    } last_sel_t;

    typedef enum logic [1:0] {
        JMP_DISPATCH,
        JMP_NEXT,
        JMP_LOOP
    } jump_t;

    // One control word of the microprogram
    typedef struct packed {
        logic              emit;
        mark_sel_t         mark_sel;
        space_sel_t        space_sel;
        last_sel_t         last_sel;
        logic              shift;
        logic              cnt_load;
        logic [CntW-1:0]   cnt_init;
        jump_t             jmp;
        upc_t              target;
    } ucode_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic        emit_en;
        logic        shift_en;
        logic        last;
        mark_sel_t   mark_sel;
        space_sel_t  space_sel;
    } irpe_ctl_t;

    // Control store
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{emit: 1'b0, mark_sel: MK_560, space_sel: SP_ZERO, last_sel: LAST_NO,
              shift: 1'b0, cnt_load: 1'b0, cnt_init: '0, jmp: JMP_DISPATCH,
              target: UA_IDLE};
        unique case (addr)
            UA_IDLE: begin
                w.jmp = JMP_DISPATCH;
            end
            UA_NEC_HDR: begin
                w.emit      = 1'b1;
                w.mark_sel  = MK_4500;
                w.space_sel = SP_4500;
                w.cnt_load  = 1'b1;
                w.cnt_init  = NEC_BITS_M1;
                w.jmp       = JMP_NEXT;
                w.target    = UA_NEC_BIT;
            end
            UA_NEC_BIT: begin
                w.emit      = 1'b1;
                w.mark_sel  = MK_560;
                w.space_sel = SP_NEC_BIT;
                w.shift     = 1'b1;
                w.jmp       = JMP_LOOP;
                w.target    = UA_NEC_END;
            end
            UA_NEC_END: begin
                w.emit      = 1'b1;
                w.mark_sel  = MK_560;
                w.space_sel = SP_ZERO;
                w.last_sel  = LAST_YES;
                w.jmp       = JMP_NEXT;
                w.target    = UA_IDLE;
            end
            UA_SIRC_HDR: begin
                w.emit      = 1'b1;
                w.mark_sel  = MK_2400;
                w.space_sel = SP_600;
                w.cnt_load  = 1'b1;
                w.cnt_init  = SIRC_BITS_M1;
                w.jmp       = JMP_NEXT;
                w.target    = UA_SIRC_BIT;
            end
            UA_SIRC_BIT: begin
                w.emit      = 1'b1;
                w.mark_sel  = MK_SIRC_BIT;
                w.space_sel = SP_600;
                w.last_sel  = LAST_CNT_ZERO;
                w.shift     = 1'b1;
                w.jmp       = JMP_LOOP;
                w.target    = UA_IDLE;
            end
            default: begin
                w.jmp = JMP_DISPATCH;
            end
        endcase
        return w;
    endfunction

    // Entry point of each protocol's routine
    function automatic upc_t dispatch(input logic [ProtoW-1:0] proto);
        upc_t a;
        case (proto)
            PROTO_NEC_A, PROTO_NEC_B: a = UA_NEC_HDR;
            PROTO_SIRC:               a = UA_SIRC_HDR;
            default:                  a = UA_IDLE;
        endcase
        return a;
    endfunction

endpackage

[design/irpe_sequencer.sv]
// ----------------------------------------------------------------------------
// irpe_sequencer
// Step counter, loop counter and control store of the pulse encoder.
// ----------------------------------------------------------------------------
module irpe_sequencer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [irpe_pkg::ProtoW-1:0]  protocol,
    input  logic                         out_free,
    output logic                         idle,
    output irpe_pkg::irpe_ctl_t          ctl
);
    import irpe_pkg::*;

    upc_t            upc_reg, upc_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    ucode_t          word;
    logic            step_en;
    logic            cnt_zero;

    assign word     = ucode_rom(upc_reg);
    assign step_en  = !(word.emit && !out_free);
    assign cnt_zero = (cnt_reg == '0);
    assign idle     = (upc_reg == UA_IDLE);

    always_comb begin
        upc_next = upc_reg;
        if (step_en) begin
            unique case (word.jmp)
                JMP_DISPATCH: upc_next = start ? dispatch(protocol) : UA_IDLE;
                JMP_NEXT:     upc_next = word.target;
                JMP_LOOP:     upc_next = cnt_zero ? word.target : upc_reg;
                default:      upc_next = UA_IDLE;
            endcase
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (step_en) begin
            if (word.cnt_load) begin
                cnt_next = word.cnt_init;
            end else if (word.jmp == JMP_LOOP && !cnt_zero) begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        ctl.emit_en   = word.emit && step_en;
        ctl.shift_en  = word.shift && step_en;
        ctl.mark_sel  = word.mark_sel;
        ctl.space_sel = word.space_sel;
        case (word.last_sel)
            LAST_YES:      ctl.last = 1'b1;
            LAST_CNT_ZERO: ctl.last = cnt_zero;
            default:       ctl.last = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_IDLE;
            cnt_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/irpe_datapath.sv]
// ----------------------------------------------------------------------------
// irpe_datapath
// Address registers, bit shifter and output register of the pulse encoder.
// ----------------------------------------------------------------------------
module irpe_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [irpe_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [irpe_pkg::AddrW-1:0]    cfg_data,
    input  logic                          load,
    input  logic [irpe_pkg::ProtoW-1:0]   protocol,
    input  logic [irpe_pkg::CmdW-1:0]     command,
    input  logic [irpe_pkg::SaddrW-1:0]   sirc_address,
    input  irpe_pkg::irpe_ctl_t           ctl,
    output logic                          out_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [irpe_pkg::DurW-1:0]     mark_us,
    output logic [irpe_pkg::DurW-1:0]     space_us,
    output logic                          last_pair
);
    import irpe_pkg::*;

    logic [AddrW-1:0]  addr_a_reg, addr_b_reg;
    logic [ShiftW-1:0] shift_reg, shift_next;
    logic              valid_reg, valid_next;
    logic [DurW-1:0]   mark_reg, space_reg, mark_next, space_next;
    logic              last_reg;
    logic [AddrW-1:0]  nec_addr;
    logic              bit_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_a_reg <= NEC_ADDR_A_RST;
            addr_b_reg <= NEC_ADDR_B_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NEC_ADDRESS_A: addr_a_reg <= cfg_data;
                CFG_NEC_ADDRESS_B: addr_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nec_addr = (protocol == PROTO_NEC_B) ? addr_b_reg : addr_a_reg;
    assign bit_now  = shift_reg[0];

    always_comb begin
        shift_next = shift_reg;
        if (load) begin
            if (protocol == PROTO_SIRC) begin
                shift_next = {{(ShiftW-12){1'b0}}, sirc_address, command[6:0]};
            end else begin
                shift_next = {~command, command, ~nec_addr, nec_addr};
            end
        end else if (ctl.shift_en) begin
            shift_next = {1'b0, shift_reg[ShiftW-1:1]};
        end
    end

    always_comb begin
        case (ctl.mark_sel)
            MK_4500:     mark_next = T_4500;
            MK_2400:     mark_next = T_2400;
            MK_SIRC_BIT: mark_next = bit_now ? T_1200 : T_600;
            default:     mark_next = T_560;
        endcase
        case (ctl.space_sel)
            SP_4500:    space_next = T_4500;
            SP_600:     space_next = T_600;
            SP_NEC_BIT: space_next = bit_now ? T_1690 : T_560;
            default:    space_next = T_0;
        endcase
    end

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.emit_en) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (ctl.emit_en) begin
            mark_reg  <= mark_next;
            space_reg <= space_next;
            last_reg  <= ctl.last;
        end
    end

    assign m_valid   = valid_reg;
    assign mark_us   = mark_reg;
    assign space_us  = space_reg;
    assign last_pair = last_reg;

endmodule

[design/ir_remote_pulse_encoder.sv]
// ----------------------------------------------------------------------------
// ir_remote_pulse_encoder
// NEC (short header) and SIRC-12 IR transmit framing as mark/space pairs.
// ----------------------------------------------------------------------------
// Each input transaction is one button send request; the block answers with
// the frame as a run of (mark_us, space_us) pairs, tlast on the final pair.
// Protocols 0 and 1 send NEC with a 4500/4500 header, address byte from
// register nec_address_a or nec_address_b, its complement, the command and
// its complement, LSB-first, then a 560/0 end mark: 34 pairs. Protocol 2
// sends SIRC-12: a 2400/600 header and 12 bits (command bits 6..0, then the
// 5-bit address): 13 pairs. Protocol 3 is taken and produces nothing.
// A small microprogram steps through the frame, one pair per clock unless
// the result side stalls; once a request is taken, s_tready stays low until
// its routine is done. The output register lets the next request be taken
// while the last pair still waits on m_tready.
// Configuration writes are always accepted (cfg_ready high); write them only
// while no frame is in flight. Indexes 2 and 3 are ignored.
module ir_remote_pulse_encoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [irpe_pkg::STdataW-1:0]   s_tdata,  // [7:0] command, [12:8] sirc_address
    input  logic [irpe_pkg::ProtoW-1:0]    s_tuser,  // [1:0] protocol
    // Result pairs
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irpe_pkg::MTdataW-1:0]   m_tdata,  // [12:0] mark_us, [25:13] space_us
    output logic                           m_tlast,  // last_pair
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irpe_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [irpe_pkg::AddrW-1:0]     cfg_data
);
    import irpe_pkg::*;

    logic               idle;
    logic               accept;
    logic               out_free;
    irpe_ctl_t          ctl;
    logic [DurW-1:0]    mark_us;
    logic [DurW-1:0]    space_us;
    logic [CmdW-1:0]    command;
    logic [SaddrW-1:0]  sirc_address;

    // Unpack the request
    assign command      = s_tdata[CmdW-1:0];
    assign sirc_address = s_tdata[CmdW+SaddrW-1:CmdW];

    // Take a request only when the sequencer sits at its dispatch step
    assign s_tready  = idle;
    assign accept    = s_tvalid && idle;
    assign cfg_ready = 1'b1;

    irpe_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .protocol (s_tuser),
        .out_free (out_free),
        .idle     (idle),
        .ctl      (ctl)
    );

    irpe_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .load         (accept),
        .protocol     (s_tuser),
        .command      (command),
        .sirc_address (sirc_address),
        .ctl          (ctl),
        .out_free     (out_free),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .mark_us      (mark_us),
        .space_us     (space_us),
        .last_pair    (m_tlast)
    );

    // Pack the result, zero padding on top
    assign m_tdata = {{(MTdataW-2*DurW){1'b0}}, space_us, mark_us};

endmodule

[bench/tb_ir_remote_pulse_encoder.sv]
// ----------------------------------------------------------------------------
// tb_ir_remote_pulse_encoder
// Self-checking bench for the NEC / SIRC-12 IR pulse encoder.
// ----------------------------------------------------------------------------
// Button requests go in on the s_ stream and the frame comes back as
// mark/space pairs on the m_ stream. A predictor keeps its own copy of the
// two NEC address registers. For every accepted request it queues the pairs
// that the frame must carry, and each result transaction is checked field by
// field against the oldest queued pair. A short directed table covers field
// extremes, every protocol code and the ignored fields. Four random phases
// follow, each under its own register setting. Both stream sides idle at
// random, except in one phase that runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_ir_remote_pulse_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import irpe_pkg::*;

    // Protocol code with no routine behind it, and the register indexes
    // past the end of the list; the block must ignore all of them.
    localparam logic [ProtoW-1:0]  PROTO_UNUSED = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_3 = 2'd3;

    // Frame timing in microseconds
    localparam logic [DurW-1:0] NEC_HDR_US        = 13'd4500;
    localparam logic [DurW-1:0] NEC_MARK_US       = 13'd560;
    localparam logic [DurW-1:0] NEC_ONE_SPACE_US  = 13'd1690;
    localparam logic [DurW-1:0] NEC_ZERO_SPACE_US = 13'd560;
    localparam logic [DurW-1:0] NEC_END_SPACE_US  = 13'd0;
    localparam logic [DurW-1:0] SIRC_HDR_MARK_US  = 13'd2400;
    localparam logic [DurW-1:0] SIRC_ONE_MARK_US  = 13'd1200;
    localparam logic [DurW-1:0] SIRC_UNIT_US      = 13'd600;

    localparam logic [AddrW-1:0] ADDR_A_AFTER_RESET = 8'h07;
    localparam logic [AddrW-1:0] ADDR_B_AFTER_RESET = 8'h04;

    localparam int MAX_GAP       = 8;
    localparam int ITEMS_PER_RUN = 20;   // counted requests per random phase
    localparam int SETTLE_CYCLES = 4;    // settling time for a trailing unused-code request
    localparam int IDLE_LIMIT    = 2000; // cycles without any transaction

    typedef struct packed {
        logic [DurW-1:0] mark_us;
        logic [DurW-1:0] space_us;
        logic            last_pair;
    } ir_pair_t;

    // One directed request. With has_word set, the frame's data bits are
    // typed in (NEC: {~cmd, cmd, ~addr, addr}; SIRC: {addr, cmd[6:0]}).
    typedef struct packed {
        logic [ProtoW-1:0] proto;
        logic [CmdW-1:0]   cmd;
        logic [SaddrW-1:0] saddr;
        logic              has_word;
        logic [31:0]       word;
    } ir_request_t;

    localparam int N_DIRECTED = 19;

    // All rows run with the address registers at their reset values.
    ir_request_t directed_requests [0:N_DIRECTED-1] = '{
        '{PROTO_NEC_A,  8'h00, 5'h00, 1'b1, 32'hFF00F807},
        '{PROTO_NEC_A,  8'hFF, 5'h1F, 1'b1, 32'h00FFF807},
        '{PROTO_NEC_B,  8'h00, 5'h00, 1'b1, 32'hFF00FB04},
        '{PROTO_NEC_B,  8'hFF, 5'h1F, 1'b1, 32'h00FFFB04},
        '{PROTO_NEC_A,  8'h55, 5'h0A, 1'b0, 32'h0},
        '{PROTO_NEC_B,  8'hAA, 5'h15, 1'b0, 32'h0},
        '{PROTO_SIRC,   8'h00, 5'h00, 1'b1, 32'h000},
        '{PROTO_SIRC,   8'h7F, 5'h1F, 1'b1, 32'hFFF},
        '{PROTO_SIRC,   8'h80, 5'h00, 1'b1, 32'h000},
        '{PROTO_SIRC,   8'hFF, 5'h00, 1'b1, 32'h07F},
        '{PROTO_SIRC,   8'h00, 5'h1F, 1'b1, 32'hF80},
        '{PROTO_SIRC,   8'h2A, 5'h15, 1'b0, 32'h0},
        '{PROTO_SIRC,   8'hD5, 5'h0A, 1'b0, 32'h0},
        '{PROTO_UNUSED, 8'hFF, 5'h1F, 1'b1, 32'h0},
        '{PROTO_UNUSED, 8'h00, 5'h00, 1'b1, 32'h0},
        '{PROTO_NEC_A,  8'h01, 5'h10, 1'b0, 32'h0},
        '{PROTO_UNUSED, 8'h5A, 5'h05, 1'b1, 32'h0},
        '{PROTO_SIRC,   8'h01, 5'h01, 1'b0, 32'h0},
        '{PROTO_NEC_B,  8'h80, 5'h00, 1'b0, 32'h0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [STdataW-1:0]    s_tdata;
    logic [ProtoW-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [MTdataW-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CfgIdxW-1:0]    cfg_index;
    logic [AddrW-1:0]      cfg_data;

    // Predictor's copy of the register file
    logic [AddrW-1:0] nec_addr_a_copy;
    logic [AddrW-1:0] nec_addr_b_copy;

    // Pairs still owed by the block, oldest first
    ir_pair_t pending_pairs [$];

    // Typed-in data word of the request now on the input stream
    logic        cur_has_word;
    logic [31:0] cur_word;

    bit no_idling;  // both sides run without gaps while set
    int errors;
    int idle_cycles;
    int n_nec, n_sirc, n_unused, n_pairs, n_writes;

    ir_remote_pulse_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] command, [12:8] sirc_address
        .s_tuser   (s_tuser),   // [1:0] protocol
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [12:0] mark_us, [25:13] space_us
        .m_tlast   (m_tlast),   // last_pair
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Queue the pairs of one frame. Without a typed-in word, build the data
    // bits from the request and the current register copy.
    task automatic queue_frame_pairs(input logic [ProtoW-1:0] proto,
                                     input logic [CmdW-1:0] cmd,
                                     input logic [SaddrW-1:0] saddr,
                                     input logic has_word,
                                     input logic [31:0] typed_word);
        logic [AddrW-1:0] addr;
        logic [31:0]      word;
        addr = (proto == PROTO_NEC_B) ? nec_addr_b_copy : nec_addr_a_copy;
        case (proto) inside
            PROTO_NEC_A, PROTO_NEC_B: begin
                // address, ~address, command, ~command, sent LSB-first
                word = has_word ? typed_word : {~cmd, cmd, ~addr, addr};
                pending_pairs.push_back('{NEC_HDR_US, NEC_HDR_US, 1'b0});
                for (int i = 0; i < 32; i++) begin
                    pending_pairs.push_back('{NEC_MARK_US,
                        word[i] ? NEC_ONE_SPACE_US : NEC_ZERO_SPACE_US, 1'b0});
                end
                pending_pairs.push_back('{NEC_MARK_US, NEC_END_SPACE_US, 1'b1});
                n_nec++;
            end
            PROTO_SIRC: begin
                // 7 command bits, then 5 address bits; command bit 7 drops out
                word = has_word ? typed_word : {20'd0, saddr, cmd[6:0]};
                pending_pairs.push_back('{SIRC_HDR_MARK_US, SIRC_UNIT_US, 1'b0});
                for (int i = 0; i < 12; i++) begin
                    pending_pairs.push_back('{
                        word[i] ? SIRC_ONE_MARK_US : SIRC_UNIT_US,
                        SIRC_UNIT_US, logic'(i == 11)});
                end
                n_sirc++;
            end
            default: begin
                // Unused code: taken, no frame
                n_unused++;
            end
        endcase
    endtask

    // Track register writes, queue frames of accepted requests, and check
    // every result transaction against the oldest owed pair.
    always @(posedge aclk) begin
        ir_pair_t owed;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NEC_ADDRESS_A: nec_addr_a_copy = cfg_data;
                    CFG_NEC_ADDRESS_B: nec_addr_b_copy = cfg_data;
                    default: ;  // ignored index
                endcase
                n_writes++;
            end
            if (s_tvalid && s_tready)
                queue_frame_pairs(s_tuser, s_tdata[7:0], s_tdata[12:8],
                                  cur_has_word, cur_word);
            if (m_tvalid && m_tready) begin
                n_pairs++;
                if (pending_pairs.size() == 0) begin
                    $error("unexpected pair: mark_us %0d space_us %0d last_pair %0b",
                           m_tdata[12:0], m_tdata[25:13], m_tlast);
                    errors++;
                end else begin
                    owed = pending_pairs.pop_front();
                    if (m_tdata[12:0] !== owed.mark_us) begin
                        $error("mark_us: expected %0d, got %0d",
                               owed.mark_us, m_tdata[12:0]);
                        errors++;
                    end
                    if (m_tdata[25:13] !== owed.space_us) begin
                        $error("space_us: expected %0d, got %0d",
                               owed.space_us, m_tdata[25:13]);
                        errors++;
                    end
                    if (m_tlast !== owed.last_pair) begin
                        $error("last_pair: expected %0b, got %0b",
                               owed.last_pair, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d pairs owed",
                     IDLE_LIMIT, pending_pairs.size());
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall a random number of cycles before each pair
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idling ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            // hold ready until a pair moves
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Present one request after a random gap and hold it until taken.
    // Valid stays high when the gap is zero.
    task automatic send_request(input logic [ProtoW-1:0] proto,
                                input logic [CmdW-1:0] cmd,
                                input logic [SaddrW-1:0] saddr,
                                input logic has_word,
                                input logic [31:0] typed_word);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata      = {3'b000, saddr, cmd};
        s_tuser      = proto;
        cur_has_word = has_word;
        cur_word     = typed_word;
        s_tvalid     = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid, wait out every owed pair, then wait SETTLE_CYCLES so
    // that a trailing unused-code request has drained too.
    task automatic drain_frames;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [AddrW-1:0] value);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [ProtoW-1:0] proto;
        logic [AddrW-1:0]  addr_a, addr_b;
        int                counted;
        int                pick;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cur_has_word = 1'b0;
        cur_word     = '0;
        no_idling    = 1'b0;
        errors       = 0;
        idle_cycles  = 0;
        n_nec        = 0;
        n_sirc       = 0;
        n_unused     = 0;
        n_pairs      = 0;
        n_writes     = 0;
        nec_addr_a_copy = ADDR_A_AFTER_RESET;
        nec_addr_b_copy = ADDR_B_AFTER_RESET;

        // Hold reset, release at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table under the reset register values
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_requests[i].proto, directed_requests[i].cmd,
                         directed_requests[i].saddr, directed_requests[i].has_word,
                         directed_requests[i].word);
        end

        // Random phases: both address extremes, a random setting with the
        // ignored indexes, then back to the reset values. Phase 1 runs
        // with no idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            drain_frames();
            case (phase)
                0: begin addr_a = 8'h00; addr_b = 8'hFF; end
                1: begin addr_a = 8'hFF; addr_b = 8'h00; end
                2: begin
                    addr_a = 8'($urandom_range(0, 255));
                    addr_b = 8'($urandom_range(0, 255));
                end
                default: begin
                    addr_a = ADDR_A_AFTER_RESET;
                    addr_b = ADDR_B_AFTER_RESET;
                end
            endcase
            write_register(CFG_NEC_ADDRESS_A, addr_a);
            write_register(CFG_NEC_ADDRESS_B, addr_b);
            if (phase == 2) begin
                write_register(CFG_UNUSED_2, 8'($urandom_range(0, 255)));
                write_register(CFG_UNUSED_3, 8'($urandom_range(0, 255)));
            end
            no_idling = (phase == 1);

            // Unused-code requests are sprinkled in but do not count
            counted = 0;
            while (counted < ITEMS_PER_RUN) begin
                pick = $urandom_range(0, 9);
                if (pick < 3)      proto = PROTO_NEC_A;
                else if (pick < 6) proto = PROTO_NEC_B;
                else if (pick < 9) proto = PROTO_SIRC;
                else               proto = PROTO_UNUSED;
                send_request(proto, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)), 1'b0, 32'h0);
                if (proto != PROTO_UNUSED) counted++;
            end
        end

        drain_frames();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (pending_pairs.size() != 0) begin
            $error("%0d pairs never arrived", pending_pairs.size());
            errors++;
        end

        $display("Sent %0d NEC, %0d SIRC and %0d unused-code requests; %0d register writes.",
                 n_nec, n_sirc, n_unused, n_writes);
        $display("Checked %0d mark/space pairs, %0d mismatches.", n_pairs, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
